@@ src/aavr_pkg.sv @@
package aavr_pkg;

	// default field format
	localparam int COMPONENT_WIDTH = 16;
	localparam int FRACTION_BITS   = 14;

	// Q30 one
	localparam logic [30:0] ONE_Q = 31'h4000_0000;

	// pipeline depths of the unit-vector path
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;
	localparam int UNIT_LAT   = 3 + SQRT_STEPS + DIV_STEPS + 1;

	// pipeline depths of the sine/cosine path
	localparam int HORNER_TERMS = 5;
	localparam int HORNER_LAT   = 3;
	localparam int TRIG_LAT     = 2 + HORNER_TERMS * HORNER_LAT + 2;

	// square-root cell data: remainder n - root^2 and partial root
	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// divider cell data: remainder, divisor, partial quotient
	typedef struct packed {
		logic [65:0] rem;
		logic [33:0] den;
		logic [30:0] quo;
	} div_t;

	// values that ride along the Horner chain unchanged
	typedef struct packed {
		logic [29:0] x2;
		logic [29:0] x;
		logic        swap;
		logic [1:0]  quad;
	} trig_side_t;

	// Horner chain data: running sine and cosine terms in Q30
	typedef struct packed {
		logic [30:0] ts;
		logic [30:0] tc;
		trig_side_t  side;
	} horner_t;

endpackage

@@ src/aavr_sqrt_cell.sv @@
module aavr_sqrt_cell #(
	parameter int B = 0
) (
	input  logic            clk,
	input  logic            en,
	input  aavr_pkg::sqrt_t prv,
	output aavr_pkg::sqrt_t nxt
);

	logic [65:0] trial;
	aavr_pkg::sqrt_t res;
	aavr_pkg::sqrt_t res_q;

	// try setting root bit B: (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
	always_comb begin
		trial = (66'(prv.root) << (B + 1)) + (66'(1) << (2 * B));
		res   = prv;
		if (66'(prv.rem) >= trial) begin
			res.rem     = 64'(66'(prv.rem) - trial);
			res.root[B] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res;
		end
	end

	assign nxt = res_q;

endmodule

@@ src/aavr_div_cell.sv @@
module aavr_div_cell #(
	parameter int B = 0
) (
	input  logic           clk,
	input  logic           en,
	input  aavr_pkg::div_t prv,
	output aavr_pkg::div_t nxt
);

	logic [65:0] dsh;
	aavr_pkg::div_t res;
	aavr_pkg::div_t res_q;

	// restoring step for quotient bit B
	always_comb begin
		dsh = 66'(prv.den) << B;
		res = prv;
		if (prv.rem >= dsh) begin
			res.rem    = prv.rem - dsh;
			res.quo[B] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res;
		end
	end

	assign nxt = res_q;

endmodule

@@ src/aavr_horner_cell.sv @@
module aavr_horner_cell #(
	parameter int KS = 6,
	parameter int KC = 2
) (
	input  logic              clk,
	input  logic              en,
	input  aavr_pkg::horner_t prv,
	output aavr_pkg::horner_t nxt
);

	// reciprocals for the constant divides, error below one count
	localparam logic [31:0] RS  = 32'((64'd1 << 32) / KS);
	localparam logic [31:0] RC  = 32'((64'd1 << 32) / KC);
	localparam logic [31:0] HS  = 32'(KS / 2);
	localparam logic [31:0] HC  = 32'(KC / 2);
	localparam logic [31:0] KSW = 32'(KS);
	localparam logic [31:0] KCW = 32'(KC);

	logic [61:0] ps, pc;
	logic [63:0] es, ec;
	logic [31:0] rs, rc, qs, qc;

	logic [31:0] vs_s1, vc_s1, vs_s2, vc_s2, qes_s2, qec_s2;
	aavr_pkg::trig_side_t side_s1, side_s2;
	aavr_pkg::horner_t out_q;

	// stage 1: x2 * term, rounded, plus half divisor
	always_comb begin
		ps = 62'(prv.side.x2) * 62'(prv.ts) + (62'(1) << 29);
		pc = 62'(prv.side.x2) * 62'(prv.tc) + (62'(1) << 29);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vs_s1   <= ps[61:30] + HS;
			vc_s1   <= pc[61:30] + HC;
			side_s1 <= prv.side;
		end
	end

	// stage 2: quotient estimate by reciprocal
	always_comb begin
		es = 64'(vs_s1) * 64'(RS);
		ec = 64'(vc_s1) * 64'(RC);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qes_s2  <= es[63:32];
			qec_s2  <= ec[63:32];
			vs_s2   <= vs_s1;
			vc_s2   <= vc_s1;
			side_s2 <= side_s1;
		end
	end

	// stage 3: one correction step, then one minus quotient
	always_comb begin
		rs = vs_s2 - qes_s2 * KSW;
		rc = vc_s2 - qec_s2 * KCW;
		qs = (rs >= KSW) ? qes_s2 + 32'd1 : qes_s2;
		qc = (rc >= KCW) ? qec_s2 + 32'd1 : qec_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.ts   <= aavr_pkg::ONE_Q - qs[30:0];
			out_q.tc   <= aavr_pkg::ONE_Q - qc[30:0];
			out_q.side <= side_s2;
		end
	end

	assign nxt = out_q;

endmodule

@@ src/aavr_unit.sv @@
module aavr_unit #(
	parameter int W = aavr_pkg::COMPONENT_WIDTH
) (
	input  logic               clk,
	input  logic               en,
	input  logic [W-1:0]       raw_x,
	input  logic [W-1:0]       raw_y,
	input  logic [W-1:0]       raw_z,
	output logic signed [31:0] u_x,
	output logic signed [31:0] u_y,
	output logic signed [31:0] u_z
);

	localparam int SQ = aavr_pkg::SQRT_STEPS;
	localparam int DV = aavr_pkg::DIV_STEPS;

	logic [W-1:0]  raw [3];
	logic [W-1:0]  magw [3];
	logic [31:0]   mag_c [3];
	logic          neg_c [3];
	logic          zero_c;

	logic [31:0]   mag_s1 [3];
	logic          neg_s1 [3];
	logic          zero_s1;
	logic [63:0]   sq_s2 [3];
	logic [31:0]   mag_s2 [3];
	logic          neg_s2 [3];
	logic          zero_s2;
	logic [63:0]   n2_s3;
	logic [31:0]   mag_s3 [3];
	logic [3:0]    sz_s3;

	logic [31:0]   magd_q [SQ][3];
	logic [3:0]    szd_q [SQ+DV];

	aavr_pkg::sqrt_t sqc [SQ+1];
	aavr_pkg::div_t  dvc [3][DV+1];

	logic signed [31:0] u_q [3];

	assign raw[0] = raw_x;
	assign raw[1] = raw_y;
	assign raw[2] = raw_z;

	// magnitudes, then a common left shift until the largest reaches 2^30
	always_comb begin
		logic [31:0] mx;
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = raw[i][W-1];
			magw[i]  = raw[i][W-1] ? W'(-raw[i]) : raw[i];
			mag_c[i] = 32'(magw[i]);
		end
		mx = mag_c[0];
		if (mag_c[1] > mx) mx = mag_c[1];
		if (mag_c[2] > mx) mx = mag_c[2];
		zero_c = (mx == 32'd0);
		for (int k = 4; k >= 0; k--) begin
			if (mx < (32'd1 << (31 - (1 << k)))) begin
				mx = mx << (1 << k);
				for (int i = 0; i < 3; i++) mag_c[i] = mag_c[i] << (1 << k);
			end
		end
	end

	// normalize, square, sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= neg_c[i];
				sq_s2[i]  <= 64'(mag_s1[i]) * 64'(mag_s1[i]);
				mag_s2[i] <= mag_s1[i];
				neg_s2[i] <= neg_s1[i];
				mag_s3[i] <= mag_s2[i];
			end
			zero_s1 <= zero_c;
			zero_s2 <= zero_s1;
			n2_s3   <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sz_s3   <= {zero_s2, neg_s2[2], neg_s2[1], neg_s2[0]};
		end
	end

	// side data waits for the root and the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			magd_q[0] <= mag_s3;
			for (int k = 1; k < SQ; k++) magd_q[k] <= magd_q[k-1];
			szd_q[0] <= sz_s3;
			for (int k = 1; k < SQ + DV; k++) szd_q[k] <= szd_q[k-1];
		end
	end

	// integer square root, one root bit per cell
	assign sqc[0].rem  = n2_s3;
	assign sqc[0].root = '0;

	for (genvar g = 0; g < SQ; g++) begin : g_sqrt
		aavr_sqrt_cell #(.B(SQ - 1 - g)) u_cell (
			.clk (clk),
			.en  (en),
			.prv (sqc[g]),
			.nxt (sqc[g+1])
		);
	end

	// rounded m * 2^30 / norm as (m * 2^31 + norm) / (2 * norm)
	for (genvar i = 0; i < 3; i++) begin : g_comp
		assign dvc[i][0].rem = (66'(magd_q[SQ-1][i]) << 31) + 66'(sqc[SQ].root);
		assign dvc[i][0].den = {2'b00, sqc[SQ].root} << 1;
		assign dvc[i][0].quo = '0;

		for (genvar g = 0; g < DV; g++) begin : g_div
			aavr_div_cell #(.B(DV - 1 - g)) u_cell (
				.clk (clk),
				.en  (en),
				.prv (dvc[i][g]),
				.nxt (dvc[i][g+1])
			);
		end
	end

	// sign back on, zero vector forced to zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (szd_q[SQ+DV-1][3]) begin
					u_q[i] <= '0;
				end else if (szd_q[SQ+DV-1][i]) begin
					u_q[i] <= -$signed(32'(dvc[i][DV].quo));
				end else begin
					u_q[i] <= $signed(32'(dvc[i][DV].quo));
				end
			end
		end
	end

	assign u_x = u_q[0];
	assign u_y = u_q[1];
	assign u_z = u_q[2];

endmodule

@@ src/axis_angle_vector_rotation_top.sv @@
// Channel  | Dir | Fields (tdata, lowest bit first)
// s_axis   | in  | axis_x, axis_y, axis_z, turn_angle, vec_x, vec_y, vec_z
// m_axis   | out | out_x, out_y, out_z
//
// One request per clock when the output side keeps up; 73 register stages, from
// the input register to the output register, lie between a request and its result.
// The depth is set by the unit-vector path: 32 root cells and 31 divider cells.
// arst_n clears the valid chain only; data registers are not reset.
// A result waiting at the output freezes the whole chain, and s_axis_tready
// drops until that result is taken.
module axis_angle_vector_rotation_top #(
	parameter int COMPONENT_WIDTH = aavr_pkg::COMPONENT_WIDTH,
	parameter int FRACTION_BITS   = aavr_pkg::FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// axis_x, axis_y, axis_z, turn_angle, vec_x, vec_y, vec_z, zero pad
	input  logic [((7*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_x, out_y, out_z, zero pad
	output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	localparam int W      = COMPONENT_WIDTH;
	localparam int IN_W   = 7 * W;
	localparam int OUT_W  = 3 * W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
	localparam int TL     = aavr_pkg::TRIG_LAT;
	localparam int UL     = aavr_pkg::UNIT_LAT;
	localparam int DLY    = UL - TL;
	localparam int TOTAL  = 1 + UL + 5;
	localparam int HT     = aavr_pkg::HORNER_TERMS;
	localparam int SH     = 30 - FRACTION_BITS;
	localparam logic [37:0] RND = (38'(1) << SH) >> 1;
	localparam logic [37:0] LIM = 38'(1) << FRACTION_BITS;
	localparam int OUT_LIM = 1 << FRACTION_BITS;
	localparam logic [47:0] PI_Q46 = 48'hC90FDAA22169;
	localparam int SIN_DIV [HT] = '{110, 72, 42, 20, 6};
	localparam int COS_DIV [HT] = '{90, 56, 30, 12, 2};

	// quadrant codes
	localparam logic [1:0] QD_FIRST  = 2'd0;
	localparam logic [1:0] QD_SECOND = 2'd1;
	localparam logic [1:0] QD_THIRD  = 2'd2;
	localparam logic [1:0] QD_FOURTH = 2'd3;

	// signed Q30 product, magnitude rounded half up
	function automatic logic signed [35:0] smulq(input logic signed [34:0] a,
			input logic signed [31:0] b);
		logic        neg;
		logic [34:0] ua;
		logic [31:0] ub;
		logic [65:0] p;
		logic [35:0] m;
		neg = a[34] ^ b[31];
		ua  = a[34] ? 35'(-a) : 35'(a);
		ub  = b[31] ? 32'(-b) : 32'(b);
		p   = 66'(ua) * 66'(ub) + (66'(1) << 29);
		m   = p[65:30];
		smulq = neg ? -$signed(m) : $signed(m);
	endfunction

	logic              en;
	logic [TOTAL-1:0]  vld_q;
	logic [IN_W-1:0]   in_s1;

	logic [15:0]       ang;
	logic [13:0]       r;
	logic              swap_c;
	logic [13:0]       rf;
	logic [62:0]       xprod;
	logic [29:0]       x_s2;
	logic              swap_s2;
	logic [1:0]        quad_s2;
	logic [60:0]       x2prod;
	aavr_pkg::horner_t hz_s3;
	aavr_pkg::horner_t hc [HT+1];
	logic [60:0]       svprod;
	logic [30:0]       sv_s19, cv_s19;
	logic              swap_s19;
	logic [1:0]        quad_s19;
	logic signed [31:0] s0, c0, s_c, c_c;
	logic signed [31:0] s_s20, c_s20;
	logic signed [33:0] t_s20;
	logic signed [31:0] sdly_q [DLY];
	logic signed [31:0] cdly_q [DLY];
	logic signed [33:0] tdly_q [DLY];

	logic signed [31:0] ax [3];
	logic signed [31:0] vv [3];
	logic signed [32:0] ta_s69 [3];
	logic signed [31:0] sa_s69 [3];
	logic signed [31:0] ax_s69 [3];
	logic signed [31:0] vv_s69 [3];
	logic signed [31:0] c_s69;
	logic signed [32:0] taa_s70 [3][3];
	logic signed [31:0] sa_s70 [3];
	logic signed [31:0] vv_s70 [3];
	logic signed [31:0] c_s70;
	logic signed [33:0] m_c [3][3];
	logic signed [33:0] m_s71 [3][3];
	logic signed [31:0] vv_s71 [3];
	logic signed [33:0] p_s72 [3][3];
	logic [W-1:0]       res_c [3];
	logic [W-1:0]       out_s73 [3];

	// global advance: stall only while a result waits
	assign en            = !vld_q[TOTAL-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[TOTAL-1];
	assign m_axis_tdata  = OUT_TW'({out_s73[2], out_s73[1], out_s73[0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL-2:0], s_axis_tvalid};
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= s_axis_tdata[IN_W-1:0];
		end
	end

	// unit axis and unit vector
	aavr_unit #(.W(W)) u_unit_axis (
		.clk   (clk),
		.en    (en),
		.raw_x (in_s1[W-1:0]),
		.raw_y (in_s1[2*W-1:W]),
		.raw_z (in_s1[3*W-1:2*W]),
		.u_x   (ax[0]),
		.u_y   (ax[1]),
		.u_z   (ax[2])
	);

	aavr_unit #(.W(W)) u_unit_vec (
		.clk   (clk),
		.en    (en),
		.raw_x (in_s1[5*W-1:4*W]),
		.raw_y (in_s1[6*W-1:5*W]),
		.raw_z (in_s1[7*W-1:6*W]),
		.u_x   (vv[0]),
		.u_y   (vv[1]),
		.u_z   (vv[2])
	);

	// octant fold and angle in Q30 radians
	always_comb begin
		ang    = 16'(32'(in_s1[4*W-1:3*W]));
		r      = ang[13:0];
		swap_c = (r > 14'h2000);
		rf     = swap_c ? 14'(15'h4000 - 15'(r)) : r;
		xprod  = 63'(rf) * 63'(PI_Q46) + (63'(1) << 30);
		x2prod = 61'(x_s2) * 61'(x_s2) + (61'(1) << 29);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2            <= xprod[60:31];
			swap_s2         <= swap_c;
			quad_s2         <= ang[15:14];
			hz_s3.ts        <= aavr_pkg::ONE_Q;
			hz_s3.tc        <= aavr_pkg::ONE_Q;
			hz_s3.side.x2   <= x2prod[59:30];
			hz_s3.side.x    <= x_s2;
			hz_s3.side.swap <= swap_s2;
			hz_s3.side.quad <= quad_s2;
		end
	end

	// Taylor series, one Horner term per cell
	assign hc[0] = hz_s3;

	for (genvar g = 0; g < HT; g++) begin : g_horner
		aavr_horner_cell #(.KS(SIN_DIV[g]), .KC(COS_DIV[g])) u_cell (
			.clk (clk),
			.en  (en),
			.prv (hc[g]),
			.nxt (hc[g+1])
		);
	end

	assign svprod = 61'(hc[HT].side.x) * 61'(hc[HT].ts) + (61'(1) << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s19   <= svprod[60:30];
			cv_s19   <= hc[HT].tc;
			swap_s19 <= hc[HT].side.swap;
			quad_s19 <= hc[HT].side.quad;
		end
	end

	// undo octant swap, then quadrant
	always_comb begin
		s0 = swap_s19 ? $signed(32'(cv_s19)) : $signed(32'(sv_s19));
		c0 = swap_s19 ? $signed(32'(sv_s19)) : $signed(32'(cv_s19));
		case (quad_s19)
			QD_FIRST: begin
				s_c = s0;
				c_c = c0;
			end
			QD_SECOND: begin
				s_c = c0;
				c_c = -s0;
			end
			QD_THIRD: begin
				s_c = -s0;
				c_c = -c0;
			end
			QD_FOURTH: begin
				s_c = -c0;
				c_c = s0;
			end
			default: begin
				s_c = s0;
				c_c = c0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s20 <= s_c;
			c_s20 <= c_c;
			t_s20 <= $signed(34'(aavr_pkg::ONE_Q)) - 34'(c_c);
		end
	end

	// sine/cosine wait for the unit vectors
	always_ff @(posedge clk) begin
		if (en) begin
			sdly_q[0] <= s_s20;
			cdly_q[0] <= c_s20;
			tdly_q[0] <= t_s20;
			for (int k = 1; k < DLY; k++) begin
				sdly_q[k] <= sdly_q[k-1];
				cdly_q[k] <= cdly_q[k-1];
				tdly_q[k] <= tdly_q[k-1];
			end
		end
	end

	// t * u and s * u
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ta_s69[i] <= 33'(smulq(35'(tdly_q[DLY-1]), ax[i]));
				sa_s69[i] <= 32'(smulq(35'(sdly_q[DLY-1]), ax[i]));
				ax_s69[i] <= ax[i];
				vv_s69[i] <= vv[i];
			end
			c_s69 <= cdly_q[DLY-1];
		end
	end

	// outer product terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					taa_s70[i][j] <= 33'(smulq(35'(ta_s69[i]), ax_s69[j]));
				end
				sa_s70[i] <= sa_s69[i];
				vv_s70[i] <= vv_s69[i];
			end
			c_s70 <= c_s69;
		end
	end

	// matrix entries: outer product plus diagonal cosine and cross-product terms
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m_c[i][j] = 34'(taa_s70[i][j]) + ((i == j) ? 34'(c_s70) : 34'sd0);
			end
		end
		m_c[0][1] = m_c[0][1] - 34'(sa_s70[2]);
		m_c[0][2] = m_c[0][2] + 34'(sa_s70[1]);
		m_c[1][0] = m_c[1][0] + 34'(sa_s70[2]);
		m_c[1][2] = m_c[1][2] - 34'(sa_s70[0]);
		m_c[2][0] = m_c[2][0] - 34'(sa_s70[1]);
		m_c[2][1] = m_c[2][1] + 34'(sa_s70[0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s71  <= m_c;
			vv_s71 <= vv_s70;
		end
	end

	// matrix times vector
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s72[i][j] <= 34'(smulq(35'(m_s71[i][j]), vv_s71[j]));
				end
			end
		end
	end

	// row sums, round to output format, saturate
	always_comb begin
		logic signed [37:0] acc;
		logic [37:0]        mg;
		logic [37:0]        sat;
		logic [37:0]        res;
		for (int i = 0; i < 3; i++) begin
			acc = 38'(p_s72[i][0]) + 38'(p_s72[i][1]) + 38'(p_s72[i][2]);
			mg  = acc[37] ? 38'(-acc) : 38'(acc);
			mg  = (mg + RND) >> SH;
			sat = (mg > LIM) ? LIM : mg;
			res = acc[37] ? 38'(-sat) : sat;
			res_c[i] = res[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s73 <= res_c;
		end
	end

`ifndef ASSERT_OFF
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved while stalled");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[TL] |-> (s_s20 <= 32'sh4000_0000 && s_s20 >= -32'sh4000_0000 &&
			t_s20 >= 34'sd0 && t_s20 <= 34'sh0_8000_0000))
		else $error("sine or cosine out of range");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[UL] |-> (ax[0] <= 32'sh4000_0000 && ax[0] >= -32'sh4000_0000 &&
			ax[1] <= 32'sh4000_0000 && ax[1] >= -32'sh4000_0000 &&
			ax[2] <= 32'sh4000_0000 && ax[2] >= -32'sh4000_0000 &&
			vv[0] <= 32'sh4000_0000 && vv[0] >= -32'sh4000_0000 &&
			vv[1] <= 32'sh4000_0000 && vv[1] >= -32'sh4000_0000 &&
			vv[2] <= 32'sh4000_0000 && vv[2] >= -32'sh4000_0000))
		else $error("unit component above one");

	a_out_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((W < FRACTION_BITS + 2) ||
			($signed(out_s73[0]) <= OUT_LIM && $signed(out_s73[0]) >= -OUT_LIM &&
			$signed(out_s73[1]) <= OUT_LIM && $signed(out_s73[1]) >= -OUT_LIM &&
			$signed(out_s73[2]) <= OUT_LIM && $signed(out_s73[2]) >= -OUT_LIM)))
		else $error("result beyond saturation limit");
`endif

endmodule
